### rtl/glph_pkg.sv
// Package for the leaf-peeling height block: word types, codes and defaults.
// Depends on nothing; graph_leaf_peel_height takes it in.
package glph_pkg;

  // Default size of the vertex store
  localparam int MAX_VERTICES_DEF = 64;

  // Register reset and height ceiling
  localparam logic [5:0] DEPTH_RESET = 6'd2;
  localparam logic [5:0] HEIGHT_MAX  = 6'd63;

  // Command codes
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  // Input word
  typedef struct packed {
    logic       command;
    logic [5:0] end_a;
    logic [5:0] end_b;
    logic [6:0] vertex_count;
  } glph_in_t;

  // Result word
  typedef struct packed {
    logic [5:0] vertex_id;
    logic [5:0] height;
    logic       height_valid;
    logic       is_exterior;
    logic       last;
  } glph_out_t;

endpackage

### rtl/glph_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; the payload types come from glph_pkg at instantiation.
interface glph_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/graph_leaf_peel_height.sv
// Leaf-peeling height of an undirected graph: edge loader, round sequencer,
// shared leaf-test unit and result sweep. Depends on glph_pkg, glph_stream_if, glph_ram.
//
//  channel   dir  word        handshake
//  items     in   glph_in_t   valid/ready, taken when both high
//  results   out  glph_out_t  valid/ready, taken when both high
//  cfg       in   6 bits      cfg_write/cfg_data, written at the edge
//
// An add word is accepted, then both rows are read, modified and written in the
// row RAM; an ignored add word and a run word with count zero are taken in the idle
// state alone. A run word with n vertices is peeled in rounds, each vertex of a round
// being a row read then one pass through the shared leaf test, each round closed by an
// end step; each result then takes a height read, a load and a hold until the sink is ready.
// Reset is synchronous; the adjacency store is cleared at once through per-row valid
// flags, after reset and at the end of each run, with no clearing pass.
// Input is taken only when the sequencer is idle; a stalled result holds the sweep.
module graph_leaf_peel_height #(
  parameter int MAX_VERTICES = glph_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  glph_stream_if.sink         items,
  glph_stream_if.source       results,
  input  logic                cfg_write,
  input  logic [5:0]          cfg_data
);

  import glph_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // Sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_E_RDA  = 4'd1;
  localparam logic [3:0] S_E_WRA  = 4'd2;
  localparam logic [3:0] S_E_WRB  = 4'd3;
  localparam logic [3:0] S_P_RD   = 4'd4;
  localparam logic [3:0] S_P_EVAL = 4'd5;
  localparam logic [3:0] S_P_END  = 4'd6;
  localparam logic [3:0] S_O_RD   = 4'd7;
  localparam logic [3:0] S_O_LD   = 4'd8;
  localparam logic [3:0] S_O_HOLD = 4'd9;

  logic [3:0]              state;
  logic [CW-1:0]           idx;
  logic [CW-1:0]           n_cnt;
  logic [VW-1:0]           ea;
  logic [VW-1:0]           eb;
  logic [5:0]              depth;
  logic [5:0]              round;
  logic [MAX_VERTICES-1:0] peeled;
  logic [MAX_VERTICES-1:0] batch;
  logic [MAX_VERTICES-1:0] nmask;
  logic [MAX_VERTICES-1:0] rowv;
  glph_out_t               out_q;
  logic                    out_valid;

  // RAM ports
  logic                    row_we;
  logic [VW-1:0]           row_waddr;
  logic [MAX_VERTICES-1:0] row_wdata;
  logic [VW-1:0]           row_raddr;
  logic [MAX_VERTICES-1:0] row_rdata;
  logic                    h_we;
  logic [5:0]              h_rdata;

  // Decode of the incoming word
  glph_in_t                in_w;
  logic [CW-1:0]           n_calc;
  logic [MAX_VERTICES-1:0] run_mask;
  logic                    edge_ok;

  // Shared leaf test
  logic [VW-1:0]           iv;
  logic [MAX_VERTICES-1:0] row_eff;
  logic [MAX_VERTICES-1:0] live;
  logic [MAX_VERTICES-1:0] live_m1;
  logic                    leaf_hit;
  logic                    is_last;

  assign in_w = items.payload;
  assign iv   = idx[VW-1:0];

  // Clamp the count and build the in-range vertex mask
  always_comb begin
    if (int'(in_w.vertex_count) > MAX_VERTICES) begin
      n_calc = CW'(MAX_VERTICES);
    end else begin
      n_calc = CW'(in_w.vertex_count);
    end
    for (int j = 0; j < MAX_VERTICES; j++) begin
      run_mask[j] = (j < int'(n_calc));
    end
  end

  assign edge_ok = (in_w.end_a != in_w.end_b) && (int'(in_w.end_a) < MAX_VERTICES)
                   && (int'(in_w.end_b) < MAX_VERTICES);

  // Leaf test: at most one unpeeled in-range neighbour, i.e. x & (x-1) == 0
  assign row_eff  = rowv[iv] ? row_rdata : '0;
  assign live     = row_eff & ~peeled & nmask;
  assign live_m1  = live - MAX_VERTICES'(1);
  assign leaf_hit = !peeled[iv] && ((live & live_m1) == '0);
  assign is_last  = ((idx + CW'(1)) == n_cnt);

  // RAM control per state
  always_comb begin
    row_we    = 1'b0;
    row_waddr = ea;
    row_wdata = '0;
    row_raddr = iv;
    case (state)
      S_E_RDA: begin
        row_raddr = ea;
      end
      S_E_WRA: begin
        row_we    = 1'b1;
        row_waddr = ea;
        row_wdata = (rowv[ea] ? row_rdata : '0) | (MAX_VERTICES'(1) << eb);
        row_raddr = eb;
      end
      S_E_WRB: begin
        row_we    = 1'b1;
        row_waddr = eb;
        row_wdata = (rowv[eb] ? row_rdata : '0) | (MAX_VERTICES'(1) << ea);
      end
      default: begin
        row_raddr = iv;
      end
    endcase
  end

  assign h_we = (state == S_P_EVAL) && leaf_hit;

  glph_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  glph_ram #(
    .WIDTH (6),
    .DEPTH (MAX_VERTICES)
  ) u_heights (
    .clk   (clk),
    .we    (h_we),
    .waddr (iv),
    .wdata (round),
    .raddr (iv),
    .rdata (h_rdata)
  );

  assign items.ready     = (state == S_IDLE);
  assign results.valid   = out_valid;
  assign results.payload = out_q;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= DEPTH_RESET;
    end else if (cfg_write) begin
      depth <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rowv      <= '0;
      peeled    <= '0;
      batch     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      round     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (items.valid) begin
            if (in_w.command == CMD_ADD) begin
              ea <= VW'(in_w.end_a);
              eb <= VW'(in_w.end_b);
              if (edge_ok) begin
                state <= S_E_RDA;
              end
            end else if (n_calc == '0) begin
              rowv <= '0;
            end else begin
              n_cnt  <= n_calc;
              nmask  <= run_mask;
              peeled <= '0;
              batch  <= '0;
              round  <= '0;
              idx    <= '0;
              state  <= S_P_RD;
            end
          end
        end
        S_E_RDA: begin
          state <= S_E_WRA;
        end
        S_E_WRA: begin
          rowv[ea] <= 1'b1;
          state    <= S_E_WRB;
        end
        S_E_WRB: begin
          rowv[eb] <= 1'b1;
          state    <= S_IDLE;
        end
        S_P_RD: begin
          state <= S_P_EVAL;
        end
        S_P_EVAL: begin
          if (leaf_hit) begin
            batch[iv] <= 1'b1;
          end
          if (is_last) begin
            state <= S_P_END;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_P_RD;
          end
        end
        S_P_END: begin
          idx <= '0;
          if (batch == '0) begin
            state <= S_O_RD;
          end else begin
            peeled <= peeled | batch;
            batch  <= '0;
            if (round != HEIGHT_MAX) begin
              round <= round + 6'd1;
            end
            state <= S_P_RD;
          end
        end
        S_O_RD: begin
          state <= S_O_LD;
        end
        S_O_LD: begin
          out_q.vertex_id    <= 6'(idx);
          out_q.height       <= peeled[iv] ? h_rdata : 6'd0;
          out_q.height_valid <= peeled[iv];
          out_q.is_exterior  <= peeled[iv] && (h_rdata < depth);
          out_q.last         <= is_last;
          out_valid          <= 1'b1;
          state              <= S_O_HOLD;
        end
        S_O_HOLD: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            if (is_last) begin
              rowv  <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_O_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/glph_ram.sv
// Generic RAM: one write port and one read port with registered read data.
// Depends on nothing.
module glph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
